@@ rtl/direct_link_stats_table_macros.svh @@
// Assertion macros for the direct-link statistics table.
`ifndef DIRECT_LINK_STATS_TABLE_MACROS_SVH
`define DIRECT_LINK_STATS_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dlst_pkg.sv @@
// Shared types and constants for the direct-link statistics table.
`timescale 1ns / 1ps

package dlst_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 24;
    localparam int unsigned AVG_SAMPLES       = 64;

    localparam int unsigned NODE_W = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned META_W = 10;
    localparam int unsigned SUM_W  = 16;
    localparam int unsigned SAMP_W = 7;
    localparam int unsigned RCNT_W = 32;
    localparam int unsigned SLOT_W = 5;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [NODE_W-1:0]        node;
        logic [TIME_W-1:0]        last_seen;
        logic signed [META_W-1:0] last_rssi;
        logic signed [META_W-1:0] last_snr;
        logic signed [SUM_W-1:0]  rssi_sum;
        logic signed [SUM_W-1:0]  snr_sum;
        logic [SAMP_W-1:0]        samples;
        logic [RCNT_W-1:0]        count;
    } entry_t;

    // Outcome of the table search.
    typedef struct packed {
        logic ignored;
        logic evicted;
        logic hit;
    } flags_t;

    // Statistics reported with each result.
    typedef struct packed {
        logic [RCNT_W-1:0]       count;
        logic [SAMP_W-1:0]       samples;
        logic signed [SUM_W-1:0] rssi_sum;
        logic signed [SUM_W-1:0] snr_sum;
    } stats_t;

endpackage

@@ rtl/dlst_table.sv @@
// Entry memory with per-entry occupied bits and a registered read port.
`timescale 1ns / 1ps

module dlst_table #(
    parameter int unsigned TABLE_ENTRIES = dlst_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned IDX_W         = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output dlst_pkg::entry_t     rd_entry,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  dlst_pkg::entry_t     wr_entry
);

    dlst_pkg::entry_t           mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   occ_reg;
    dlst_pkg::entry_t           rd_data_reg;
    logic                       rd_occ_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                occ_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_occ_reg <= occ_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as the empty reset value.
    assign rd_entry = rd_occ_reg ? rd_data_reg : '0;

endmodule

@@ rtl/dlst_update.sv @@
// Entry update: hit accumulation or fresh allocation, plus reported statistics.
`timescale 1ns / 1ps

module dlst_update (
    input  logic [dlst_pkg::NODE_W-1:0]        in_node,
    input  logic signed [dlst_pkg::META_W-1:0] in_rssi,
    input  logic signed [dlst_pkg::META_W-1:0] in_snr,
    input  logic [dlst_pkg::TIME_W-1:0]        in_now,
    input  dlst_pkg::flags_t                   flags,
    input  dlst_pkg::entry_t                   old_entry,
    output dlst_pkg::entry_t                   new_entry,
    output dlst_pkg::stats_t                   stats
);

    // sum = (3*sum + 64*x) / 4, truncated toward zero
    function automatic logic signed [dlst_pkg::SUM_W-1:0] follow(
        input logic signed [dlst_pkg::SUM_W-1:0]  sum,
        input logic signed [dlst_pkg::META_W-1:0] x
    );
        logic signed [18:0] t;
        logic signed [18:0] r;
        t = (19'(sum) <<< 1) + 19'(sum) + (19'(x) <<< 6);
        r = (t < 0) ? (t + 19'sd3) : t;
        return dlst_pkg::SUM_W'(r >>> 2);
    endfunction

    logic [dlst_pkg::TIME_W-1:0] stamp;

    always_comb begin
        stamp = (in_now == '0) ? dlst_pkg::TIME_W'(1) : in_now;
        new_entry           = old_entry;
        new_entry.last_seen = stamp;
        new_entry.last_rssi = in_rssi;
        new_entry.last_snr  = in_snr;
        if (flags.hit) begin
            new_entry.count = old_entry.count + dlst_pkg::RCNT_W'(1);
            if (old_entry.samples < dlst_pkg::SAMP_W'(dlst_pkg::AVG_SAMPLES)) begin
                new_entry.rssi_sum = old_entry.rssi_sum + dlst_pkg::SUM_W'(in_rssi);
                new_entry.snr_sum  = old_entry.snr_sum + dlst_pkg::SUM_W'(in_snr);
                new_entry.samples  = old_entry.samples + dlst_pkg::SAMP_W'(1);
            end else begin
                new_entry.rssi_sum = follow(old_entry.rssi_sum, in_rssi);
                new_entry.snr_sum  = follow(old_entry.snr_sum, in_snr);
            end
        end else begin
            new_entry.node     = in_node;
            new_entry.rssi_sum = dlst_pkg::SUM_W'(in_rssi);
            new_entry.snr_sum  = dlst_pkg::SUM_W'(in_snr);
            new_entry.samples  = dlst_pkg::SAMP_W'(1);
            new_entry.count    = dlst_pkg::RCNT_W'(1);
        end

        if (flags.ignored) begin
            stats = '0;
        end else begin
            stats.count    = new_entry.count;
            stats.samples  = new_entry.samples;
            stats.rssi_sum = new_entry.rssi_sum;
            stats.snr_sum  = new_entry.snr_sum;
        end
    end

endmodule

@@ rtl/direct_link_stats_table.sv @@
// Top level of the direct-link statistics table: search sequencer and result register.
//
//  channel   direction  contents
//  s_*       in         received packet: node id, RSSI, SNR, timestamp
//  m_*       out        updated entry: slot, counts, sums; hit/evicted/ignored flags
//
// An item with a nonzero node id is searched with one memory read per entry through
// the single read port, then the last compare and the write-back, before the next
// item can be accepted. A zero id skips the search and goes straight to the write-back.
// Reset clears the occupied bits of all entries at once; no clearing pass is needed.
// The result register holds a result until m_tready; a pending result stalls only
// the write-back of the following item, not its search.
`timescale 1ns / 1ps

`include "direct_link_stats_table_macros.svh"

module direct_link_stats_table #(
    parameter int unsigned TABLE_ENTRIES = dlst_pkg::DEF_TABLE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] node_id, [41:32] rssi_dbm, [51:42] snr_quarter_db, [83:52] now_ms
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] slot, [36:5] receive_count, [43:37] sample_count,
    // [59:44] rssi_sum, [75:60] snr_sum
    output logic [79:0] m_tdata,
    // [0] hit, [1] evicted, [2] ignored
    output logic [2:0]  m_tuser
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned ISS_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]                          state_reg, state_next;
    logic [ISS_W-1:0]                    iss_reg, iss_next;
    logic                                rd_vld_reg;
    logic [IDX_W-1:0]                    rd_idx_reg;

    logic [dlst_pkg::NODE_W-1:0]         node_reg;
    logic signed [dlst_pkg::META_W-1:0]  rssi_reg;
    logic signed [dlst_pkg::META_W-1:0]  snr_reg;
    logic [dlst_pkg::TIME_W-1:0]         now_reg;
    logic                                ign_reg;

    logic                                found_reg;
    logic [IDX_W-1:0]                    hit_idx_reg;
    dlst_pkg::entry_t                    hit_entry_reg;
    logic                                have_empty_reg;
    logic [IDX_W-1:0]                    empty_idx_reg;
    logic [IDX_W-1:0]                    oldest_idx_reg;
    logic [dlst_pkg::TIME_W-1:0]         oldest_age_reg;

    logic                                m_tvalid_reg;
    logic [79:0]                         m_tdata_reg;
    logic [2:0]                          m_tuser_reg;

    logic                                in_acc;
    logic                                out_free;
    logic                                rd_en;
    logic [IDX_W-1:0]                    rd_addr;
    dlst_pkg::entry_t                    rd_entry;
    logic                                wr_en;
    logic                                load_out;
    logic                                cmp_en;
    logic                                rd_occ;
    logic                                rd_match;
    logic [dlst_pkg::TIME_W-1:0]         rd_age;
    logic [IDX_W-1:0]                    sel_idx;
    logic [dlst_pkg::SLOT_W-1:0]         slot_out;
    dlst_pkg::flags_t                    flags;
    dlst_pkg::entry_t                    new_entry;
    dlst_pkg::stats_t                    stats;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == S_WRITE) && out_free;
    assign wr_en    = load_out && !ign_reg;

    // Sequencer: one read issued per cycle, compare in the cycle after each read.
    always_comb begin
        state_next = state_reg;
        iss_next   = iss_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tdata[31:0] != '0) begin
                        rd_en      = 1'b1;
                        iss_next   = ISS_W'(1);
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_SCAN: begin
                if (iss_reg < ISS_W'(TABLE_ENTRIES)) begin
                    rd_en    = 1'b1;
                    rd_addr  = iss_reg[IDX_W-1:0];
                    iss_next = iss_reg + ISS_W'(1);
                end
                if (rd_vld_reg && (rd_idx_reg == LAST_IDX)) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cmp_en   = (state_reg == S_SCAN) && rd_vld_reg;
    assign rd_occ   = (rd_entry.node != '0);
    assign rd_match = rd_occ && (rd_entry.node == node_reg);
    assign rd_age   = rd_occ ? (now_reg - rd_entry.last_seen) : '1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            iss_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            rd_vld_reg <= rd_en;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Search results and payload.
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_addr;
        if (in_acc) begin
            node_reg       <= s_tdata[31:0];
            rssi_reg       <= s_tdata[41:32];
            snr_reg        <= s_tdata[51:42];
            now_reg        <= s_tdata[83:52];
            ign_reg        <= (s_tdata[31:0] == '0);
            found_reg      <= 1'b0;
            have_empty_reg <= 1'b0;
            oldest_age_reg <= '0;
            oldest_idx_reg <= '0;
        end else if (cmp_en) begin
            if (rd_match && !found_reg) begin
                found_reg     <= 1'b1;
                hit_idx_reg   <= rd_idx_reg;
                hit_entry_reg <= rd_entry;
            end
            if (!rd_occ && !have_empty_reg) begin
                have_empty_reg <= 1'b1;
                empty_idx_reg  <= rd_idx_reg;
            end
            // Later entry wins a tie on age.
            if (rd_age >= oldest_age_reg) begin
                oldest_age_reg <= rd_age;
                oldest_idx_reg <= rd_idx_reg;
            end
        end
        if (load_out) begin
            m_tdata_reg <= {4'b0, stats.snr_sum, stats.rssi_sum, stats.samples,
                            stats.count, slot_out};
            m_tuser_reg <= {flags.ignored, flags.evicted, flags.hit};
        end
    end

    always_comb begin
        priority if (found_reg) begin
            sel_idx = hit_idx_reg;
        end else if (have_empty_reg) begin
            sel_idx = empty_idx_reg;
        end else begin
            sel_idx = oldest_idx_reg;
        end
        flags.ignored = ign_reg;
        flags.hit     = !ign_reg && found_reg;
        flags.evicted = !ign_reg && !found_reg && !have_empty_reg;
        slot_out      = ign_reg ? '0 : dlst_pkg::SLOT_W'(sel_idx);
    end

    dlst_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (sel_idx),
        .wr_entry (new_entry)
    );

    dlst_update u_update (
        .in_node   (node_reg),
        .in_rssi   (rssi_reg),
        .in_snr    (snr_reg),
        .in_now    (now_reg),
        .flags     (flags),
        .old_entry (hit_entry_reg),
        .new_entry (new_entry),
        .stats     (stats)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `DLST_ASSERT_NOW(a_write_only_at_load, aclk, aresetn, wr_en, (state_reg == S_WRITE) && out_free, "memory write outside write-back")
    `DLST_ASSERT_NOW(a_write_in_range, aclk, aresetn, wr_en, sel_idx <= LAST_IDX, "write-back slot beyond table")
    `DLST_ASSERT_NEXT(a_ignored_result_zero, aclk, aresetn, load_out && ign_reg, (m_tdata == '0) && (m_tuser == 3'b100), "ignored id produced nonzero result")
    `DLST_ASSERT_NEXT(a_write_gives_result, aclk, aresetn, wr_en, m_tvalid && !m_tuser[2], "write-back without a result")

endmodule
